[sv/pse_pkg.sv]
package pse_pkg;

  localparam int unsigned DEPTH_DEF = 8;

  // command codes
  localparam logic [2:0] CMD_PUSH    = 3'd0;
  localparam logic [2:0] CMD_POP     = 3'd1;
  localparam logic [2:0] CMD_SEARCH  = 3'd2;
  localparam logic [2:0] CMD_INSERT  = 3'd3;
  localparam logic [2:0] CMD_REPLACE = 3'd4;
  localparam logic [2:0] CMD_DELETE  = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

  // cursor operations
  localparam logic [2:0] CUR_HOLD  = 3'd0;
  localparam logic [2:0] CUR_FC_M1 = 3'd1;
  localparam logic [2:0] CUR_FC    = 3'd2;
  localparam logic [2:0] CUR_POS   = 3'd3;
  localparam logic [2:0] CUR_DEC   = 3'd4;
  localparam logic [2:0] CUR_INC   = 3'd5;

  // read address select
  localparam logic [2:0] RD_NONE   = 3'd0;
  localparam logic [2:0] RD_FC_M1  = 3'd1;
  localparam logic [2:0] RD_CUR    = 3'd2;
  localparam logic [2:0] RD_CUR_M1 = 3'd3;
  localparam logic [2:0] RD_CUR_P1 = 3'd4;

  // write select
  localparam logic [2:0] WR_NONE      = 3'd0;
  localparam logic [2:0] WR_FC_VAL    = 3'd1;
  localparam logic [2:0] WR_POS_VAL   = 3'd2;
  localparam logic [2:0] WR_CUR_VAL   = 3'd3;
  localparam logic [2:0] WR_CUR_RDATA = 3'd4;

  // fill count operations
  localparam logic [1:0] FC_HOLD = 2'd0;
  localparam logic [1:0] FC_INC  = 2'd1;
  localparam logic [1:0] FC_DEC  = 2'd2;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] value;
    logic [3:0]         position;
  } pse_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic               found;
    logic [3:0]         found_index;
    logic [3:0]         count;
  } pse_out_t;

  typedef struct packed {
    logic       ld_item;
    logic [2:0] cur_op;
    logic [2:0] rd_sel;
    logic [2:0] wr_sel;
    logic [1:0] fc_op;
    logic       set_status;
    logic [1:0] status;
    logic       cap_rd;
    logic       set_found;
    logic       ld_out;
  } pse_ctl_t;

  typedef struct packed {
    logic [2:0] command;
    logic       full;
    logic       empty;
    logic       pos_bad;
    logic       cur_at_tgt;
    logic       del_done;
    logic       match;
    logic       cur_zero;
    logic       out_free;
  } pse_stat_t;

endpackage

[sv/positional_stack_engine_unit.sv]
// channel | ports                             | payload
// input   | in_valid, in_ready, in_data       | pse_in_t  (command, value, position)
// result  | out_valid, out_ready, out_data    | pse_out_t (status, read_value, found,
//         |                                   |            found_index, count)
//
// one command at a time through a stack memory with one read port, one write port and registered read.
// pop reads the top entry; search scans entries from the top down; insert and delete
// shift entries one at a time
// (one memory read and one write per moved entry).
// synchronous active-low reset empties the stack; memory contents are not cleared.
// a result waits in the output register; the next command is taken meanwhile, and
// the controller holds its finished result only while that register is still full.
module positional_stack_engine_unit import pse_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  pse_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output pse_out_t out_data
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  pse_ctl_t      ctl;
  pse_stat_t     stat;
  logic [CW-1:0] fill_cnt;

  pse_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  pse_datapath #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .ctl       (ctl),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .fill_cnt  (fill_cnt)
  );

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_cnt <= CW'(DEPTH))
    else $error("fill count above stack depth");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again before command finished");

  a_idle_count_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ready && !in_valid) |=> $stable(fill_cnt))
    else $error("fill count moved while idle");
`endif

endmodule

[sv/pse_ram.sv]
module pse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[sv/pse_datapath.sv]
module pse_datapath import pse_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF,
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  pse_in_t       in_data,
  input  pse_ctl_t      ctl,
  output pse_stat_t     stat,
  output logic          out_valid,
  input  logic          out_ready,
  output pse_out_t      out_data,
  output logic [CW-1:0] fill_cnt
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned PW = (CW > 4) ? CW : 4;

  pse_in_t     item_r;
  logic [CW-1:0] fc_r, fc_nxt;
  logic [CW-1:0] cur_r, cur_nxt;
  logic [1:0]  status_r;
  logic [31:0] rd_r;
  logic        found_r;
  logic [3:0]  fidx_r;
  logic        out_valid_r;
  pse_out_t    out_r;

  logic [PW-1:0] fc_ext, pos_ext, cur_ext;
  logic [CW-1:0] fc_m1, cur_m1, tgt;
  logic [CW:0]   cur_p1;
  logic          pos_lt;

  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [31:0]   wr_data, rdata;

  assign fc_ext  = PW'(fc_r);
  assign pos_ext = PW'(item_r.position);
  assign cur_ext = PW'(cur_r);
  assign fc_m1   = fc_r - CW'(1);
  assign cur_m1  = cur_r - CW'(1);
  assign cur_p1  = {1'b0, cur_r} + (CW+1)'(1);
  assign pos_lt  = pos_ext < fc_ext;
  // insert position clamps to the top
  assign tgt     = pos_lt ? pos_ext[CW-1:0] : fc_r;

  always_comb begin
    stat.command    = item_r.command;
    stat.full       = (fc_r == CW'(DEPTH));
    stat.empty      = (fc_r == '0);
    stat.pos_bad    = !pos_lt;
    stat.cur_at_tgt = (cur_r == tgt);
    stat.del_done   = (cur_p1 >= {1'b0, fc_r});
    stat.match      = (rdata == item_r.value);
    stat.cur_zero   = (cur_r == '0);
    stat.out_free   = !out_valid_r || out_ready;
  end

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = cur_r[AW-1:0];
    case (ctl.rd_sel)
      RD_FC_M1:  rd_addr = fc_m1[AW-1:0];
      RD_CUR:    rd_addr = cur_r[AW-1:0];
      RD_CUR_M1: rd_addr = cur_m1[AW-1:0];
      RD_CUR_P1: rd_addr = cur_p1[AW-1:0];
      default:   rd_en = 1'b0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = cur_r[AW-1:0];
    wr_data = item_r.value;
    case (ctl.wr_sel)
      WR_FC_VAL:    wr_addr = fc_r[AW-1:0];
      WR_POS_VAL:   wr_addr = pos_ext[AW-1:0];
      WR_CUR_VAL:   wr_addr = cur_r[AW-1:0];
      WR_CUR_RDATA: wr_data = rdata;
      default:      wr_en = 1'b0;
    endcase
  end

  pse_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rdata)
  );

  always_comb begin
    case (ctl.cur_op)
      CUR_FC_M1: cur_nxt = fc_m1;
      CUR_FC:    cur_nxt = fc_r;
      CUR_POS:   cur_nxt = pos_ext[CW-1:0];
      CUR_DEC:   cur_nxt = cur_m1;
      CUR_INC:   cur_nxt = cur_p1[CW-1:0];
      default:   cur_nxt = cur_r;
    endcase
  end

  always_comb begin
    case (ctl.fc_op)
      FC_INC:  fc_nxt = fc_r + CW'(1);
      FC_DEC:  fc_nxt = fc_m1;
      default: fc_nxt = fc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fc_r <= fc_nxt;
      if (ctl.ld_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (ctl.ld_item) begin
      item_r   <= in_data;
      status_r <= ST_OK;
      rd_r     <= '0;
      found_r  <= 1'b0;
      fidx_r   <= '0;
    end else begin
      if (ctl.set_status) begin
        status_r <= ctl.status;
      end
      if (ctl.cap_rd) begin
        rd_r <= rdata;
      end
      if (ctl.set_found) begin
        found_r <= 1'b1;
        fidx_r  <= cur_ext[3:0];
      end
    end
    if (ctl.ld_out) begin
      out_r.status      <= status_r;
      out_r.read_value  <= rd_r;
      out_r.found       <= found_r;
      out_r.found_index <= fidx_r;
      out_r.count       <= fc_ext[3:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign fill_cnt  = fc_r;

endmodule

[sv/pse_ctrl.sv]
module pse_ctrl import pse_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  pse_stat_t stat,
  output pse_ctl_t  ctl
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_POP  = 4'd2;
  localparam logic [3:0] S_SRD  = 4'd3;
  localparam logic [3:0] S_SCMP = 4'd4;
  localparam logic [3:0] S_ICHK = 4'd5;
  localparam logic [3:0] S_IWR  = 4'd6;
  localparam logic [3:0] S_DCHK = 4'd7;
  localparam logic [3:0] S_DWR  = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    ctl       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.ld_item = 1'b1;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        state_nxt = S_FIN;
        case (stat.command)
          CMD_PUSH: begin
            if (stat.full) begin
              ctl.set_status = 1'b1;
              ctl.status     = ST_FULL;
            end else begin
              ctl.wr_sel = WR_FC_VAL;
              ctl.fc_op  = FC_INC;
            end
          end
          CMD_POP: begin
            if (stat.empty) begin
              ctl.set_status = 1'b1;
              ctl.status     = ST_EMPTY;
            end else begin
              ctl.rd_sel = RD_FC_M1;
              state_nxt  = S_POP;
            end
          end
          CMD_SEARCH: begin
            if (!stat.empty) begin
              ctl.cur_op = CUR_FC_M1;
              state_nxt  = S_SRD;
            end
          end
          CMD_INSERT: begin
            if (stat.full) begin
              ctl.set_status = 1'b1;
              ctl.status     = ST_FULL;
            end else begin
              ctl.cur_op = CUR_FC;
              state_nxt  = S_ICHK;
            end
          end
          CMD_REPLACE: begin
            if (stat.pos_bad) begin
              ctl.set_status = 1'b1;
              ctl.status     = ST_BADPOS;
            end else begin
              ctl.wr_sel = WR_POS_VAL;
            end
          end
          CMD_DELETE: begin
            if (stat.empty) begin
              ctl.set_status = 1'b1;
              ctl.status     = ST_EMPTY;
            end else if (stat.pos_bad) begin
              ctl.set_status = 1'b1;
              ctl.status     = ST_BADPOS;
            end else begin
              ctl.cur_op = CUR_POS;
              state_nxt  = S_DCHK;
            end
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_POP: begin
        ctl.cap_rd = 1'b1;
        ctl.fc_op  = FC_DEC;
        state_nxt  = S_FIN;
      end
      S_SRD: begin
        ctl.rd_sel = RD_CUR;
        state_nxt  = S_SCMP;
      end
      S_SCMP: begin
        // scan runs from the top down, first hit wins
        if (stat.match) begin
          ctl.set_found = 1'b1;
          state_nxt     = S_FIN;
        end else if (stat.cur_zero) begin
          state_nxt = S_FIN;
        end else begin
          ctl.cur_op = CUR_DEC;
          state_nxt  = S_SRD;
        end
      end
      S_ICHK: begin
        if (stat.cur_at_tgt) begin
          ctl.wr_sel = WR_CUR_VAL;
          ctl.fc_op  = FC_INC;
          state_nxt  = S_FIN;
        end else begin
          ctl.rd_sel = RD_CUR_M1;
          state_nxt  = S_IWR;
        end
      end
      S_IWR: begin
        ctl.wr_sel = WR_CUR_RDATA;
        ctl.cur_op = CUR_DEC;
        state_nxt  = S_ICHK;
      end
      S_DCHK: begin
        if (stat.del_done) begin
          ctl.fc_op = FC_DEC;
          state_nxt = S_FIN;
        end else begin
          ctl.rd_sel = RD_CUR_P1;
          state_nxt  = S_DWR;
        end
      end
      S_DWR: begin
        ctl.wr_sel = WR_CUR_RDATA;
        ctl.cur_op = CUR_INC;
        state_nxt  = S_DCHK;
      end
      S_FIN: begin
        // wait for the result register to free up
        if (stat.out_free) begin
          ctl.ld_out = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[test/positional_stack_engine_unit_test.sv]
module positional_stack_engine_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pse_pkg::*;

  localparam int STACK_DEPTH = DEPTH_DEF;
  localparam int RANDOM_CMDS = 1100;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_START  = 2500;
  localparam int HOLD_CYCLES = 500;
  localparam int CALM_START  = 6000;
  localparam int CALM_END    = 9000;
  localparam int DRAIN_WAIT  = 40;

  // command codes the block must treat as no-ops
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  pse_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  pse_out_t out_data;

  pse_in_t  pending_cmds[$];
  pse_out_t expected_results[$];

  // shadow copy of the stack
  logic [31:0] stack_words[STACK_DEPTH];
  int          stack_fill = 0;

  int  cycle_cnt = 0;
  int  stall_left = 0;
  bit  in_fire = 1'b0;
  int  mismatch_count = 0;
  int  cmd_seen[8];
  int  status_seen[4];
  int  search_hits = 0;

  positional_stack_engine_unit #(.DEPTH(STACK_DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    mismatch_count++;
  endtask

  task automatic enqueue_cmd(input logic [2:0] c, input logic [31:0] v, input logic [3:0] p);
    pse_in_t item;
    item.command  = c;
    item.value    = v;
    item.position = p;
    pending_cmds.push_back(item);
  endtask

  // applies one command to the shadow stack and returns its result
  function automatic pse_out_t apply_stack_cmd(input pse_in_t cmd);
    pse_out_t res;
    int       pos;
    int       at;
    int       k;
    res = '0;
    pos = int'(cmd.position);
    case (cmd.command)
      CMD_PUSH: begin
        if (stack_fill >= STACK_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          stack_words[stack_fill] = cmd.value;
          stack_fill++;
        end
      end
      CMD_POP: begin
        if (stack_fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          stack_fill--;
          res.read_value = stack_words[stack_fill];
        end
      end
      CMD_SEARCH: begin
        k = stack_fill - 1;
        while (k >= 0 && !res.found) begin
          if (stack_words[k] == cmd.value) begin
            res.found       = 1'b1;
            res.found_index = k[3:0];
          end
          k--;
        end
      end
      CMD_INSERT: begin
        if (stack_fill >= STACK_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          // a position past the top appends
          at = (pos < stack_fill) ? pos : stack_fill;
          for (k = stack_fill; k > at; k--) stack_words[k] = stack_words[k - 1];
          stack_words[at] = cmd.value;
          stack_fill++;
        end
      end
      CMD_REPLACE: begin
        if (pos >= stack_fill) res.status = ST_BADPOS;
        else stack_words[pos] = cmd.value;
      end
      CMD_DELETE: begin
        if (stack_fill == 0) begin
          res.status = ST_EMPTY;
        end else if (pos >= stack_fill) begin
          res.status = ST_BADPOS;
        end else begin
          for (k = pos; k + 1 < stack_fill; k++) stack_words[k] = stack_words[k + 1];
          stack_fill--;
        end
      end
      default: begin
      end
    endcase
    res.count = stack_fill[3:0];
    return res;
  endfunction

  // receiver hold-off, counted down on its own
  always @(posedge clk) begin
    if (stall_left > 0) stall_left--;
    else if (cycle_cnt == HOLD_START) stall_left = HOLD_CYCLES;
  end

  // monitor: input transfers feed the predictor, result transfers are checked
  always @(posedge clk) begin
    pse_out_t want;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timed out after %0d cycles with %0d results outstanding",
               cycle_cnt, expected_results.size());
      $display("FAILURE");
      $finish;
    end
    in_fire = rst_n && in_valid && in_ready;
    if (in_fire) begin
      cmd_seen[in_data.command]++;
      expected_results.push_back(apply_stack_cmd(in_data));
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing outstanding", out_data));
      end else begin
        want = expected_results.pop_front();
        status_seen[want.status]++;
        if (want.found) search_hits++;
        if (out_data.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_data.status, want.status));
        if (out_data.read_value !== want.read_value)
          report_mismatch($sformatf("read_value %h, want %h",
                                    out_data.read_value, want.read_value));
        if (out_data.found !== want.found)
          report_mismatch($sformatf("found %b, want %b", out_data.found, want.found));
        if (out_data.found_index !== want.found_index)
          report_mismatch($sformatf("found_index %0d, want %0d",
                                    out_data.found_index, want.found_index));
        if (out_data.count !== want.count)
          report_mismatch($sformatf("count %0d, want %0d", out_data.count, want.count));
      end
    end
  end

  // driver: offers the next command once the previous transfer is done
  always @(negedge clk) begin
    bit calm;
    calm = (cycle_cnt >= CALM_START) && (cycle_cnt < CALM_END);
    if (rst_n && (!in_valid || in_fire)) begin
      if (pending_cmds.size() > 0 && (calm || $urandom_range(99) >= 11)) begin
        in_valid <= 1'b1;
        in_data  <= pending_cmds.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= (stall_left == 0) && (calm || $urandom_range(99) >= 11);
  end

  initial begin
    int          i;
    int          pick;
    bit          filling;
    logic [2:0]  c;
    logic [31:0] v;
    logic [3:0]  p;

    // empty stack corner cases
    enqueue_cmd(CMD_POP,     32'd0,        4'd0);
    enqueue_cmd(CMD_DELETE,  32'd0,        4'd0);
    enqueue_cmd(CMD_REPLACE, 32'd5,        4'd0);
    enqueue_cmd(CMD_SEARCH,  32'd0,        4'd0);
    enqueue_cmd(CMD_SPARE_6, 32'hffffffff, 4'd15);
    // value extremes, then inserts at the bottom and past the top
    enqueue_cmd(CMD_PUSH,    32'h7fffffff, 4'd0);
    enqueue_cmd(CMD_PUSH,    32'h80000000, 4'd15);
    enqueue_cmd(CMD_PUSH,    32'hffffffff, 4'd0);
    enqueue_cmd(CMD_PUSH,    32'h00000000, 4'd0);
    enqueue_cmd(CMD_INSERT,  32'hffffffff, 4'd0);
    enqueue_cmd(CMD_INSERT,  32'h5a5a5a5a, 4'd15);
    enqueue_cmd(CMD_REPLACE, 32'h0f0f0f0f, 4'd1);
    enqueue_cmd(CMD_REPLACE, 32'h12121212, 4'd15);
    // duplicate word: the topmost copy must be reported
    enqueue_cmd(CMD_SEARCH,  32'hffffffff, 4'd0);
    enqueue_cmd(CMD_SEARCH,  32'h12345678, 4'd0);
    enqueue_cmd(CMD_INSERT,  32'h13579bdf, 4'd2);
    enqueue_cmd(CMD_PUSH,    32'h2468ace0, 4'd0);
    // full stack
    enqueue_cmd(CMD_PUSH,    32'h11111111, 4'd0);
    enqueue_cmd(CMD_INSERT,  32'h22222222, 4'd0);
    enqueue_cmd(CMD_DELETE,  32'd0,        4'd15);
    enqueue_cmd(CMD_DELETE,  32'd0,        4'd0);
    enqueue_cmd(CMD_DELETE,  32'd0,        4'd6);
    enqueue_cmd(CMD_POP,     32'd0,        4'd0);
    enqueue_cmd(CMD_SPARE_7, 32'h00000000, 4'd0);
    enqueue_cmd(CMD_SEARCH,  32'h80000000, 4'd0);

    // random part alternates between filling and draining phases
    for (i = 0; i < RANDOM_CMDS; i++) begin
      filling = ((i / 48) % 2) == 0;
      pick = $urandom_range(99);
      if (pick < 3)       c = (pick < 2) ? CMD_SPARE_6 : CMD_SPARE_7;
      else if (pick < 18) c = CMD_SEARCH;
      else if (pick < 30) c = CMD_REPLACE;
      else if (pick < 65) c = filling ? CMD_PUSH : CMD_POP;
      else if (pick < 85) c = filling ? CMD_INSERT : CMD_DELETE;
      else if (pick < 93) c = filling ? CMD_POP : CMD_PUSH;
      else                c = filling ? CMD_DELETE : CMD_INSERT;
      pick = $urandom_range(99);
      // a small pool of words makes searches hit and duplicates common
      if (pick < 40) begin
        v = 32'($urandom_range(7)) - 32'd3;
      end else if (pick < 50) begin
        case ($urandom_range(3))
          0: v = 32'h7fffffff;
          1: v = 32'h80000000;
          2: v = 32'h00000000;
          default: v = 32'hffffffff;
        endcase
      end else begin
        v = $urandom;
      end
      p = ($urandom_range(99) < 80) ? 4'($urandom_range(STACK_DEPTH))
                                    : 4'($urandom_range(15));
      enqueue_cmd(c, v, p);
    end

    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

    $display("covered: push %0d, pop %0d, search %0d, insert %0d, replace %0d, delete %0d,",
             cmd_seen[CMD_PUSH], cmd_seen[CMD_POP], cmd_seen[CMD_SEARCH],
             cmd_seen[CMD_INSERT], cmd_seen[CMD_REPLACE], cmd_seen[CMD_DELETE]);
    $display("  spare %0d; outcomes: ok %0d, full %0d, empty %0d, bad position %0d, hits %0d",
             cmd_seen[CMD_SPARE_6] + cmd_seen[CMD_SPARE_7], status_seen[ST_OK],
             status_seen[ST_FULL], status_seen[ST_EMPTY], status_seen[ST_BADPOS],
             search_hits);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[positional_stack_engine_unit.f]
sv/pse_pkg.sv
sv/pse_ram.sv
sv/pse_datapath.sv
sv/pse_ctrl.sv
sv/positional_stack_engine_unit.sv
test/positional_stack_engine_unit_test.sv
